/* design/fwdm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwdm_pkg
// Shared types and constants of the four-wheel drive mixer: command codes,
// register indexes, the quarter-wave sine table and the per-motor result.
// ----------------------------------------------------------------------------
package fwdm_pkg;

  localparam int NUM_MOTORS = 4;

  localparam logic [1:0] MODE_MOVE  = 2'd0;
  localparam logic [1:0] MODE_ORBIT = 2'd1;
  localparam logic [1:0] MODE_SPIN  = 2'd2;
  localparam logic [1:0] MODE_STOP  = 2'd3;

  localparam logic REG_BASE_SPEED = 1'b0;
  localparam logic REG_SLOW_SPEED = 1'b1;

  localparam logic [9:0] ORBIT_OFFSET = 10'd15;
  localparam logic [7:0] DUTY_MAX     = 8'd255;
  localparam int         SINE_Q       = 15;

  // sin(k deg) in Q1.15, k = 0..90, rounded to nearest
  localparam logic [15:0] QSINE [0:90] = '{
    16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,  16'd2856,  16'd3425,
    16'd3993,  16'd4560,  16'd5126,  16'd5690,  16'd6252,  16'd6813,  16'd7371,
    16'd7927,  16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668, 16'd11207,
    16'd11743, 16'd12275, 16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876,
    16'd15384, 16'd15886, 16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
    16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498,
    16'd21926, 16'd22348, 16'd22763, 16'd23170, 16'd23571, 16'd23965, 16'd24351,
    16'd24730, 16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510, 16'd26842,
    16'd27166, 16'd27482, 16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932,
    16'd29197, 16'd29452, 16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
    16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499, 16'd31651, 16'd31795,
    16'd31928, 16'd32052, 16'd32166, 16'd32270, 16'd32365, 16'd32449, 16'd32524,
    16'd32589, 16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763, 16'd32768
  };

  typedef struct packed {
    logic [7:0] duty;
    logic       fwd;
    logic       rev;
  } motor_cmd_t;

  // floor(x * 11 / 10); the divide by ten is a multiply by 3277 / 2^15,
  // exact for x * 11 below 2816
  function automatic logic [8:0] boost_of(input logic [7:0] x);
    logic [11:0] x11;
    logic [23:0] prod;
    begin
      x11  = 12'(x) * 12'd11;
      prod = 24'(x11) * 24'd3277;
      boost_of = prod[23:15];
    end
  endfunction

endpackage

/* design/fwdm_wheel.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwdm_wheel
// One wheel lane: sine of a whole-degree angle times a speed, truncated
// toward zero, turned into duty and direction lines.
// ----------------------------------------------------------------------------
module fwdm_wheel #(
  parameter int SINE_FRAC_BITS = 15
) (
  input  logic [8:0]         deg,
  input  logic [8:0]         speed,
  input  logic               negate,
  output fwdm_pkg::motor_cmd_t cmd
);

  localparam int SW     = SINE_FRAC_BITS + 1;
  localparam int UP     = (SINE_FRAC_BITS > fwdm_pkg::SINE_Q) ?
                          SINE_FRAC_BITS - fwdm_pkg::SINE_Q : 0;
  localparam int DOWN   = (SINE_FRAC_BITS < fwdm_pkg::SINE_Q) ?
                          fwdm_pkg::SINE_Q - SINE_FRAC_BITS : 0;
  localparam int RND_SH = (DOWN > 0) ? DOWN - 1 : 0;
  localparam logic [16:0] RND = (DOWN > 0) ? (17'd1 << RND_SH) : 17'd0;

  logic [6:0]    idx;
  logic          sine_neg;
  logic [16:0]   q_ext;
  logic [16:0]   q_scaled;
  logic [SW-1:0] mag;
  logic [SW+8:0] prod;
  logic [9:0]    whole;
  logic          neg;

  // fold the full wave onto the quarter-wave table
  always_comb begin
    sine_neg = 1'b0;
    if (deg <= 9'd90) begin
      idx = deg[6:0];
    end else if (deg <= 9'd180) begin
      idx = 7'(9'd180 - deg);
    end else if (deg <= 9'd270) begin
      idx = 7'(deg - 9'd180);
      sine_neg = 1'b1;
    end else begin
      idx = 7'(9'd360 - deg);
      sine_neg = 1'b1;
    end
  end

  assign q_ext    = {1'b0, fwdm_pkg::QSINE[idx]};
  assign q_scaled = (DOWN > 0) ? ((q_ext + RND) >> DOWN) : (q_ext << UP);
  assign mag      = q_scaled[SW-1:0];
  assign prod     = (SW + 9)'(mag) * (SW + 9)'(speed);
  assign whole    = prod[SW+8:SINE_FRAC_BITS];

  // a product that truncates to zero counts as non-negative
  assign neg = (sine_neg ^ negate) && (whole != 10'd0);

  assign cmd.duty = (whole[9:8] != 2'd0) ? fwdm_pkg::DUTY_MAX : whole[7:0];
  assign cmd.fwd  = !neg;
  assign cmd.rev  = neg;

endmodule

/* design/four_wheel_drive_mixer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_wheel_drive_mixer
// Mixes one drive command into duty and direction lines for four motors.
// ----------------------------------------------------------------------------
// Usage:
//   Drive commands arrive on the in_ channel (valid/ready); each request
//   yields exactly one set of four motor commands on the out_ channel.
//   cfg_we writes base_speed (index 0) or slow_speed (index 1);
//   write them only while no request is in flight.
//   A request accepted into the input register moves into the output
//   register once that register is free or its result is being taken,
//   and out_valid rises with it. One request per cycle passes while the
//   receiver does not stall;
//   the critical path is the sine fold, table lookup and one multiplier per
//   wheel lane between the input and output registers.
//   When the receiver stalls, the output register holds its result and the
//   input register holds one more request; in_ready drops once both are full
//   and rises in the cycle the receiver takes the result.
//   Reset clears both valid flags, the speed registers and the held duties;
//   a stop command shows the duties of the last non-stop command.
// ----------------------------------------------------------------------------
module four_wheel_drive_mixer #(
  parameter int SINE_FRAC_BITS = 15
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_mode,
  input  logic [8:0] in_angle_deg,
  input  logic [1:0] in_rotation,
  input  logic       in_clockwise,
  input  logic [7:0] in_spin_speed,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_motor0_duty,
  output logic       out_motor0_fwd,
  output logic       out_motor0_rev,
  output logic [7:0] out_motor1_duty,
  output logic       out_motor1_fwd,
  output logic       out_motor1_rev,
  output logic [7:0] out_motor2_duty,
  output logic       out_motor2_fwd,
  output logic       out_motor2_rev,
  output logic [7:0] out_motor3_duty,
  output logic       out_motor3_fwd,
  output logic       out_motor3_rev
);

  localparam int NM = fwdm_pkg::NUM_MOTORS;

  logic [7:0] base_speed_r, slow_speed_r;
  logic [8:0] base_boost_r, slow_boost_r;

  logic       a_valid_r;
  logic [1:0] a_mode_r;
  logic [8:0] a_angle_r;
  logic [1:0] a_rot_r;
  logic       a_cw_r;
  logic [7:0] a_spin_r;
  logic       a_go;

  logic       out_valid_r, out_valid_nxt;
  fwdm_pkg::motor_cmd_t out_motor_r [NM];
  fwdm_pkg::motor_cmd_t motor_nxt   [NM];
  fwdm_pkg::motor_cmd_t wheel_cmd   [NM];
  logic [7:0] held_duty_r [NM];

  logic [8:0] ang, deg_minus, deg_plus;
  logic [9:0] orbit_fast;
  logic [9:0] orbit_slow_sum;
  logic       orbit_slow_neg;
  logic [7:0] orbit_slow_mag;
  logic [7:0] orbit_fast_duty;

  // configuration; boosted speeds are kept alongside
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_speed_r <= '0;
      slow_speed_r <= '0;
      base_boost_r <= '0;
      slow_boost_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == fwdm_pkg::REG_BASE_SPEED) begin
        base_speed_r <= cfg_wdata;
        base_boost_r <= fwdm_pkg::boost_of(cfg_wdata);
      end else begin
        slow_speed_r <= cfg_wdata;
        slow_boost_r <= fwdm_pkg::boost_of(cfg_wdata);
      end
    end
  end

  assign a_go     = !out_valid_r || out_ready;
  assign in_ready = !a_valid_r || a_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ready) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_mode_r  <= in_mode;
      a_angle_r <= in_angle_deg;
      a_rot_r   <= in_rotation;
      a_cw_r    <= in_clockwise;
      a_spin_r  <= in_spin_speed;
    end
  end

  // headings 45 - a and 45 + a, reduced into 0..359
  always_comb begin
    ang       = (a_angle_r >= 9'd360) ? 9'(a_angle_r - 9'd360) : a_angle_r;
    deg_minus = (ang <= 9'd45) ? 9'(9'd45 - ang) : 9'(9'd405 - ang);
    deg_plus  = (ang >= 9'd315) ? 9'(ang - 9'd315) : 9'(ang + 9'd45);
  end

  fwdm_wheel #(.SINE_FRAC_BITS(SINE_FRAC_BITS)) u_wheel0 (
    .deg(deg_minus), .speed({1'b0, base_speed_r}), .negate(1'b1), .cmd(wheel_cmd[0])
  );
  fwdm_wheel #(.SINE_FRAC_BITS(SINE_FRAC_BITS)) u_wheel1 (
    .deg(deg_plus), .speed(base_boost_r), .negate(1'b0), .cmd(wheel_cmd[1])
  );
  fwdm_wheel #(.SINE_FRAC_BITS(SINE_FRAC_BITS)) u_wheel2 (
    .deg(deg_minus), .speed(base_boost_r), .negate(1'b0), .cmd(wheel_cmd[2])
  );
  fwdm_wheel #(.SINE_FRAC_BITS(SINE_FRAC_BITS)) u_wheel3 (
    .deg(deg_plus), .speed({1'b0, base_speed_r}), .negate(1'b1), .cmd(wheel_cmd[3])
  );

  // orbit: front pair at boost + 15, rear pair at 15 - slow
  always_comb begin
    orbit_fast      = 10'(slow_boost_r) + fwdm_pkg::ORBIT_OFFSET;
    orbit_fast_duty = (orbit_fast[9:8] != 2'd0) ? fwdm_pkg::DUTY_MAX : orbit_fast[7:0];
    orbit_slow_neg  = (10'(slow_speed_r) > fwdm_pkg::ORBIT_OFFSET);
    orbit_slow_sum  = orbit_slow_neg ? 10'(10'(slow_speed_r) - fwdm_pkg::ORBIT_OFFSET)
                                     : 10'(fwdm_pkg::ORBIT_OFFSET - 10'(slow_speed_r));
    orbit_slow_mag  = orbit_slow_sum[7:0];
  end

  always_comb begin
    logic [1:0] k;
    for (int m = 0; m < NM; m++) begin
      k = 2'(m) - a_rot_r;
      case (a_mode_r)
        fwdm_pkg::MODE_MOVE: begin
          motor_nxt[m] = wheel_cmd[k];
        end
        fwdm_pkg::MODE_ORBIT: begin
          if (m < 2) begin
            motor_nxt[m] = '{duty: orbit_fast_duty, fwd: 1'b1, rev: 1'b0};
          end else begin
            motor_nxt[m] = '{duty: orbit_slow_mag, fwd: !orbit_slow_neg,
                             rev: orbit_slow_neg};
          end
        end
        fwdm_pkg::MODE_SPIN: begin
          motor_nxt[m] = '{duty: a_spin_r, fwd: !a_cw_r, rev: a_cw_r};
        end
        default: begin
          motor_nxt[m] = '{duty: held_duty_r[m], fwd: 1'b0, rev: 1'b0};
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (a_go) begin
      out_valid_nxt = a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid_r && a_go) begin
      for (int m = 0; m < NM; m++) begin
        out_motor_r[m] <= motor_nxt[m];
      end
    end
  end

  // advance held duties as each non-stop request moves to the output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int m = 0; m < NM; m++) begin
        held_duty_r[m] <= '0;
      end
    end else if (a_valid_r && a_go && (a_mode_r != fwdm_pkg::MODE_STOP)) begin
      for (int m = 0; m < NM; m++) begin
        held_duty_r[m] <= motor_nxt[m].duty;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_motor0_duty = out_motor_r[0].duty;
  assign out_motor0_fwd  = out_motor_r[0].fwd;
  assign out_motor0_rev  = out_motor_r[0].rev;
  assign out_motor1_duty = out_motor_r[1].duty;
  assign out_motor1_fwd  = out_motor_r[1].fwd;
  assign out_motor1_rev  = out_motor_r[1].rev;
  assign out_motor2_duty = out_motor_r[2].duty;
  assign out_motor2_fwd  = out_motor_r[2].fwd;
  assign out_motor2_rev  = out_motor_r[2].rev;
  assign out_motor3_duty = out_motor_r[3].duty;
  assign out_motor3_fwd  = out_motor_r[3].fwd;
  assign out_motor3_rev  = out_motor_r[3].rev;

endmodule

/* design/fwdm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwdm_checker
// Port-level checks of the four-wheel drive mixer, bound to the top level.
// ----------------------------------------------------------------------------
module fwdm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_motor0_duty,
  input logic       out_motor0_fwd,
  input logic       out_motor0_rev,
  input logic       out_motor1_fwd,
  input logic       out_motor1_rev,
  input logic       out_motor2_fwd,
  input logic       out_motor2_rev,
  input logic       out_motor3_fwd,
  input logic       out_motor3_rev
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_motor0_duty))
    else $error("stalled result changed");

  a_dir_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_motor0_fwd && out_motor0_rev) && !(out_motor1_fwd && out_motor1_rev)
               && !(out_motor2_fwd && out_motor2_rev) && !(out_motor3_fwd && out_motor3_rev))
    else $error("both direction lines high");

  // a stop releases every motor, any other command drives every motor
  a_stop_all: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_motor0_fwd && !out_motor0_rev |->
      !out_motor1_fwd && !out_motor1_rev && !out_motor2_fwd && !out_motor2_rev
      && !out_motor3_fwd && !out_motor3_rev)
    else $error("partial stop");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without matching request");

endmodule

bind four_wheel_drive_mixer fwdm_checker u_fwdm_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_valid),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_motor0_duty(out_motor0_duty),
  .out_motor0_fwd(out_motor0_fwd),
  .out_motor0_rev(out_motor0_rev),
  .out_motor1_fwd(out_motor1_fwd),
  .out_motor1_rev(out_motor1_rev),
  .out_motor2_fwd(out_motor2_fwd),
  .out_motor2_rev(out_motor2_rev),
  .out_motor3_fwd(out_motor3_fwd),
  .out_motor3_rev(out_motor3_rev)
);

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for four_wheel_drive_mixer. A directed table covers
// reset values, every mode, heading wrap, saturation and the zero-speed
// direction case. Random commands then follow under several speed settings.
// Each accepted request is mixed by a local model of the wheel math. Every
// motor set that comes back is compared field by field with the oldest
// prediction. The sender runs in bursts and the receiver stalls, including
// one long hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NM             = fwdm_pkg::NUM_MOTORS;
  localparam int SINE_FRAC_BITS = 15;
  localparam int SINE_DOWN      = (SINE_FRAC_BITS < 15) ? 15 - SINE_FRAC_BITS : 0;
  localparam int SINE_UP        = (SINE_FRAC_BITS > 15) ? SINE_FRAC_BITS - 15 : 0;
  localparam int RANDOM_PHASES  = 7;
  localparam int PHASE_ITEMS    = 186;
  localparam int HOLD_CYCLES    = 80;
  localparam int QUIET_LIMIT    = 1000;
  localparam int MAX_PRINTS     = 40;

  typedef fwdm_pkg::motor_cmd_t [NM-1:0] drive_set_t;

  typedef struct packed {
    logic [7:0] base;
    logic [7:0] slow;
    logic [1:0] mode;
    logic [8:0] angle;
    logic [1:0] rot;
    logic       cw;
    logic [7:0] spin;
    logic       typed;
    drive_set_t want;
  } stim_row_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_index;
  logic [7:0] cfg_wdata;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] in_mode;
  logic [8:0] in_angle_deg;
  logic [1:0] in_rotation;
  logic       in_clockwise;
  logic [7:0] in_spin_speed;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_motor0_duty, out_motor1_duty, out_motor2_duty, out_motor3_duty;
  logic       out_motor0_fwd, out_motor1_fwd, out_motor2_fwd, out_motor3_fwd;
  logic       out_motor0_rev, out_motor1_rev, out_motor2_rev, out_motor3_rev;

  // typed expectation travels with the request it belongs to
  logic       row_typed;
  drive_set_t row_want;

  drive_set_t got_set;
  drive_set_t pending_sets [$];
  stim_row_t  directed_rows [$];

  logic [7:0] base_q;
  logic [7:0] slow_q;
  logic [7:0] held_duty [NM];

  int  mismatches;
  int  n_requests;
  int  n_results;
  int  n_settings;
  int  burst_left;
  bit  hold_req;
  bit  hold_done;

  wire in_fire  = in_valid & in_ready;
  wire out_fire = out_valid & out_ready;

  assign got_set = {{out_motor3_duty, out_motor3_fwd, out_motor3_rev},
                    {out_motor2_duty, out_motor2_fwd, out_motor2_rev},
                    {out_motor1_duty, out_motor1_fwd, out_motor1_rev},
                    {out_motor0_duty, out_motor0_fwd, out_motor0_rev}};

  four_wheel_drive_mixer #(
    .SINE_FRAC_BITS(SINE_FRAC_BITS)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_angle_deg   (in_angle_deg),
    .in_rotation    (in_rotation),
    .in_clockwise   (in_clockwise),
    .in_spin_speed  (in_spin_speed),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_motor0_duty(out_motor0_duty),
    .out_motor0_fwd (out_motor0_fwd),
    .out_motor0_rev (out_motor0_rev),
    .out_motor1_duty(out_motor1_duty),
    .out_motor1_fwd (out_motor1_fwd),
    .out_motor1_rev (out_motor1_rev),
    .out_motor2_duty(out_motor2_duty),
    .out_motor2_fwd (out_motor2_fwd),
    .out_motor2_rev (out_motor2_rev),
    .out_motor3_duty(out_motor3_duty),
    .out_motor3_fwd (out_motor3_fwd),
    .out_motor3_rev (out_motor3_rev)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // Wheel math
  // --------------------------------------------------------------------------
  function automatic fwdm_pkg::motor_cmd_t cmd_of(int duty, logic fwd, logic rev);
    fwdm_pkg::motor_cmd_t c;
    c.duty = duty[7:0];
    c.fwd  = fwd;
    c.rev  = rev;
    return c;
  endfunction

  function automatic drive_set_t same4(int duty, logic fwd, logic rev);
    return {NM{cmd_of(duty, fwd, rev)}};
  endfunction

  // signed speed to duty plus direction lines; zero counts as forward
  function automatic fwdm_pkg::motor_cmd_t speed_to_cmd(int v);
    int mag;
    mag = (v < 0) ? -v : v;
    return cmd_of((mag > 255) ? 255 : mag, v >= 0, v < 0);
  endfunction

  // |sin(deg)| * speed truncated toward zero, then signed
  function automatic int wheel_speed(int unsigned deg, int unsigned speed, bit negate);
    int unsigned idx;
    int unsigned m;
    bit          neg;
    neg = (deg > 180);
    if (deg <= 90)       idx = deg;
    else if (deg <= 180) idx = 180 - deg;
    else if (deg <= 270) idx = deg - 180;
    else                 idx = 360 - deg;
    m = fwdm_pkg::QSINE[idx];
    m = ((m + ((1 << SINE_DOWN) >> 1)) >> SINE_DOWN) << SINE_UP;
    m = (m * speed) >> SINE_FRAC_BITS;
    return (neg != negate) ? -int'(m) : int'(m);
  endfunction

  // expected motor set for one command; updates the held duties
  function automatic drive_set_t mix_command(logic [1:0] mode, logic [8:0] angle,
                                             logic [1:0] rot, logic cw, logic [7:0] spin);
    drive_set_t  s;
    int unsigned a, minus, plus, boost;
    int          w [NM];
    int          slow_i;
    s = '0;
    a = angle % 360;
    case (mode)
      fwdm_pkg::MODE_MOVE: begin
        boost = base_q * 11 / 10;
        minus = (405 - a) % 360;
        plus  = (45 + a) % 360;
        w[0] = wheel_speed(minus, base_q, 1'b1);
        w[1] = wheel_speed(plus, boost, 1'b0);
        w[2] = wheel_speed(minus, boost, 1'b0);
        w[3] = wheel_speed(plus, base_q, 1'b1);
        for (int k = 0; k < NM; k++) s[(k + rot) % NM] = speed_to_cmd(w[k]);
      end
      fwdm_pkg::MODE_ORBIT: begin
        slow_i = slow_q;
        boost  = slow_q * 11 / 10;
        s[0] = speed_to_cmd(int'(boost) + int'(fwdm_pkg::ORBIT_OFFSET));
        s[1] = s[0];
        s[2] = speed_to_cmd(int'(fwdm_pkg::ORBIT_OFFSET) - slow_i);
        s[3] = s[2];
      end
      fwdm_pkg::MODE_SPIN: begin
        for (int k = 0; k < NM; k++) s[k] = cmd_of(spin, ~cw, cw);
      end
      default: begin
        for (int k = 0; k < NM; k++) s[k] = cmd_of(held_duty[k], 1'b0, 1'b0);
      end
    endcase
    if (mode != fwdm_pkg::MODE_STOP) begin
      for (int k = 0; k < NM; k++) held_duty[k] = s[k].duty;
    end
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Monitors
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    if (mismatches < MAX_PRINTS) $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    drive_set_t pred;
    if (rst_n && in_fire) begin
      pred = mix_command(in_mode, in_angle_deg, in_rotation, in_clockwise, in_spin_speed);
      pending_sets.push_back(row_typed ? row_want : pred);
      n_requests++;
    end
  end

  always @(posedge clk) begin
    drive_set_t want;
    if (rst_n && out_fire) begin
      n_results++;
      if (pending_sets.size() == 0) begin
        report_mismatch("motor set with no request pending");
      end else begin
        want = pending_sets.pop_front();
        for (int k = 0; k < NM; k++) begin
          if (got_set[k].duty !== want[k].duty)
            report_mismatch($sformatf("motor%0d duty got %0d want %0d",
                                      k, got_set[k].duty, want[k].duty));
          if (got_set[k].fwd !== want[k].fwd)
            report_mismatch($sformatf("motor%0d fwd got %b want %b",
                                      k, got_set[k].fwd, want[k].fwd));
          if (got_set[k].rev !== want[k].rev)
            report_mismatch($sformatf("motor%0d rev got %b want %b",
                                      k, got_set[k].rev, want[k].rev));
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst_n && !in_fire && !out_fire) quiet++;
      else quiet = 0;
    end
    $display("[four_wheel_drive_mixer] ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall patterns, one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : receiver
    int pat;
    int span;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      pat  = $urandom_range(0, 3);
      span = $urandom_range(4, 40);
      repeat (span) begin
        case (pat)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  task automatic offer(logic [1:0] mode, logic [8:0] angle, logic [1:0] rot, logic cw,
                       logic [7:0] spin, logic typed, drive_set_t want);
    in_valid      <= 1'b1;
    in_mode       <= mode;
    in_angle_deg  <= angle;
    in_rotation   <= rot;
    in_clockwise  <= cw;
    in_spin_speed <= spin;
    row_typed     <= typed;
    row_want      <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // advance the burst; drop valid for a gap when the burst runs out
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(0, 23);
    end
  endtask

  // drain everything in flight, then write both speed registers
  task automatic set_speeds(logic [7:0] base, logic [7:0] slow);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_sets.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= fwdm_pkg::REG_BASE_SPEED;
    cfg_wdata <= base;
    @(posedge clk);
    cfg_index <= fwdm_pkg::REG_SLOW_SPEED;
    cfg_wdata <= slow;
    @(posedge clk);
    cfg_we <= 1'b0;
    base_q = base;
    slow_q = slow;
    n_settings++;
  endtask

  task automatic build_directed();
    // reset speeds: zero products stay forward, orbit shows the bare offset
    directed_rows.push_back(stim_row_t'{8'd0, 8'd0, fwdm_pkg::MODE_STOP, 9'd0, 2'd0, 1'b0,
                                        8'd0, 1'b1, same4(0, 1'b0, 1'b0)});
    directed_rows.push_back(stim_row_t'{8'd0, 8'd0, fwdm_pkg::MODE_MOVE, 9'd0, 2'd0, 1'b0,
                                        8'd0, 1'b1, same4(0, 1'b1, 1'b0)});
    directed_rows.push_back(stim_row_t'{8'd0, 8'd0, fwdm_pkg::MODE_ORBIT, 9'd0, 2'd0, 1'b0,
                                        8'd0, 1'b1, same4(15, 1'b1, 1'b0)});
    directed_rows.push_back(stim_row_t'{8'd0, 8'd0, fwdm_pkg::MODE_SPIN, 9'd0, 2'd3, 1'b1,
                                        8'd255, 1'b1, same4(255, 1'b0, 1'b1)});
    directed_rows.push_back(stim_row_t'{8'd0, 8'd0, fwdm_pkg::MODE_STOP, 9'd0, 2'd0, 1'b0,
                                        8'd0, 1'b1, same4(255, 1'b0, 1'b0)});
    directed_rows.push_back(stim_row_t'{8'd0, 8'd0, fwdm_pkg::MODE_SPIN, 9'd511, 2'd0, 1'b0,
                                        8'd0, 1'b1, same4(0, 1'b1, 1'b0)});
    // full speed: boosted wheel saturates, rotation shifts wheels onto motors
    directed_rows.push_back(stim_row_t'{8'd255, 8'd255, fwdm_pkg::MODE_MOVE, 9'd45, 2'd0,
                                        1'b0, 8'd0, 1'b1,
                                        {cmd_of(255, 1'b0, 1'b1), cmd_of(0, 1'b1, 1'b0),
                                         cmd_of(255, 1'b1, 1'b0), cmd_of(0, 1'b1, 1'b0)}});
    directed_rows.push_back(stim_row_t'{8'd255, 8'd255, fwdm_pkg::MODE_MOVE, 9'd45, 2'd1,
                                        1'b0, 8'd0, 1'b1,
                                        {cmd_of(0, 1'b1, 1'b0), cmd_of(255, 1'b1, 1'b0),
                                         cmd_of(0, 1'b1, 1'b0), cmd_of(255, 1'b0, 1'b1)}});
    directed_rows.push_back(stim_row_t'{8'd255, 8'd255, fwdm_pkg::MODE_ORBIT, 9'd0, 2'd2,
                                        1'b0, 8'd0, 1'b1,
                                        {cmd_of(240, 1'b0, 1'b1), cmd_of(240, 1'b0, 1'b1),
                                         cmd_of(255, 1'b1, 1'b0), cmd_of(255, 1'b1, 1'b0)}});
    directed_rows.push_back(stim_row_t'{8'd255, 8'd255, fwdm_pkg::MODE_STOP, 9'd0, 2'd0,
                                        1'b1, 8'd7, 1'b1,
                                        {cmd_of(240, 1'b0, 1'b0), cmd_of(240, 1'b0, 1'b0),
                                         cmd_of(255, 1'b0, 1'b0), cmd_of(255, 1'b0, 1'b0)}});
    directed_rows.push_back(stim_row_t'{8'd255, 8'd255, fwdm_pkg::MODE_MOVE, 9'd0, 2'd2,
                                        1'b0, 8'd0, 1'b0, '0});
    directed_rows.push_back(stim_row_t'{8'd255, 8'd255, fwdm_pkg::MODE_MOVE, 9'd90, 2'd3,
                                        1'b0, 8'd0, 1'b0, '0});
    directed_rows.push_back(stim_row_t'{8'd255, 8'd255, fwdm_pkg::MODE_MOVE, 9'd180, 2'd0,
                                        1'b0, 8'd0, 1'b0, '0});
    directed_rows.push_back(stim_row_t'{8'd255, 8'd255, fwdm_pkg::MODE_MOVE, 9'd270, 2'd1,
                                        1'b0, 8'd0, 1'b0, '0});
    directed_rows.push_back(stim_row_t'{8'd255, 8'd255, fwdm_pkg::MODE_MOVE, 9'd359, 2'd2,
                                        1'b0, 8'd0, 1'b0, '0});
    // headings past 359 wrap
    directed_rows.push_back(stim_row_t'{8'd255, 8'd255, fwdm_pkg::MODE_MOVE, 9'd360, 2'd3,
                                        1'b0, 8'd0, 1'b0, '0});
    directed_rows.push_back(stim_row_t'{8'd255, 8'd255, fwdm_pkg::MODE_MOVE, 9'd405, 2'd0,
                                        1'b0, 8'd0, 1'b0, '0});
    directed_rows.push_back(stim_row_t'{8'd255, 8'd255, fwdm_pkg::MODE_MOVE, 9'd511, 2'd1,
                                        1'b1, 8'd0, 1'b0, '0});
    // slow speed equal to the offset: rear pair lands on zero, forward
    directed_rows.push_back(stim_row_t'{8'd15, 8'd15, fwdm_pkg::MODE_ORBIT, 9'd0, 2'd0,
                                        1'b0, 8'd0, 1'b1,
                                        {cmd_of(0, 1'b1, 1'b0), cmd_of(0, 1'b1, 1'b0),
                                         cmd_of(31, 1'b1, 1'b0), cmd_of(31, 1'b1, 1'b0)}});
    directed_rows.push_back(stim_row_t'{8'd15, 8'd15, fwdm_pkg::MODE_MOVE, 9'd135, 2'd0,
                                        1'b0, 8'd0, 1'b0, '0});
    directed_rows.push_back(stim_row_t'{8'd15, 8'd15, fwdm_pkg::MODE_MOVE, 9'd225, 2'd1,
                                        1'b0, 8'd0, 1'b0, '0});
    directed_rows.push_back(stim_row_t'{8'd15, 8'd15, fwdm_pkg::MODE_SPIN, 9'd0, 2'd0,
                                        1'b1, 8'd128, 1'b1, same4(128, 1'b0, 1'b1)});
    directed_rows.push_back(stim_row_t'{8'd100, 8'd1, fwdm_pkg::MODE_ORBIT, 9'd0, 2'd0,
                                        1'b0, 8'd0, 1'b1,
                                        {cmd_of(14, 1'b1, 1'b0), cmd_of(14, 1'b1, 1'b0),
                                         cmd_of(16, 1'b1, 1'b0), cmd_of(16, 1'b1, 1'b0)}});
    directed_rows.push_back(stim_row_t'{8'd100, 8'd1, fwdm_pkg::MODE_MOVE, 9'd30, 2'd3,
                                        1'b0, 8'd0, 1'b0, '0});
    directed_rows.push_back(stim_row_t'{8'd100, 8'd1, fwdm_pkg::MODE_STOP, 9'd0, 2'd0,
                                        1'b0, 8'd0, 1'b0, '0});
  endtask

  initial begin : stimulus
    int         r;
    logic [1:0] mode;
    logic [8:0] angle;
    logic [7:0] base;
    logic [7:0] slow;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= fwdm_pkg::REG_BASE_SPEED;
    cfg_wdata     <= 8'd0;
    in_valid      <= 1'b0;
    in_mode       <= fwdm_pkg::MODE_STOP;
    in_angle_deg  <= 9'd0;
    in_rotation   <= 2'd0;
    in_clockwise  <= 1'b0;
    in_spin_speed <= 8'd0;
    row_typed     <= 1'b0;
    row_want      <= '0;
    base_q        = 8'd0;
    slow_q        = 8'd0;
    for (int k = 0; k < NM; k++) held_duty[k] = 8'd0;
    mismatches = 0;
    n_requests = 0;
    n_results  = 0;
    n_settings = 0;
    burst_left = 0;
    hold_req   = 1'b0;
    hold_done  = 1'b0;
    build_directed();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].base != base_q || directed_rows[i].slow != slow_q)
        set_speeds(directed_rows[i].base, directed_rows[i].slow);
      offer(directed_rows[i].mode, directed_rows[i].angle, directed_rows[i].rot,
            directed_rows[i].cw, directed_rows[i].spin, directed_rows[i].typed,
            directed_rows[i].want);
      pace();
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      base = (p == 1 || p == 3) ? 8'd255 : (p == 2 || p == 4) ? 8'd0 : 8'($urandom_range(0, 255));
      slow = (p == 1 || p == 4) ? 8'd255 : (p == 2 || p == 3) ? 8'd0 : 8'($urandom_range(0, 255));
      set_speeds(base, slow);
      // back up the pipeline once while the sender keeps pushing
      if (p == 0) hold_req = 1'b1;
      repeat (PHASE_ITEMS) begin
        r     = $urandom_range(0, 99);
        mode  = (r < 40) ? fwdm_pkg::MODE_MOVE :
                (r < 55) ? fwdm_pkg::MODE_ORBIT :
                (r < 75) ? fwdm_pkg::MODE_SPIN : fwdm_pkg::MODE_STOP;
        angle = ($urandom_range(0, 4) == 0) ? 9'($urandom_range(360, 511))
                                             : 9'($urandom_range(0, 359));
        offer(mode, angle, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
              8'($urandom_range(0, 255)), 1'b0, '0);
        pace();
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_sets.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Covered %0d drive commands under %0d speed settings, %0d motor sets checked.",
             n_requests, n_settings + 1, n_results);
    if (mismatches == 0) begin
      $display("[four_wheel_drive_mixer] OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[four_wheel_drive_mixer] ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
design/fwdm_pkg.sv
design/fwdm_wheel.sv
design/four_wheel_drive_mixer.sv
design/fwdm_checker.sv
dv/tb_top.sv
